@@ sv/i2c_byte_master_assert.svh @@
// Assertion macros shared by the i2c byte master RTL.
// Each macro expands to one labeled concurrent assertion, disabled while reset is high.
`ifndef I2C_BYTE_MASTER_ASSERT_SVH
`define I2C_BYTE_MASTER_ASSERT_SVH

// Same-cycle implication.
`define I2CBM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the following cycle.
`define I2CBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/i2cbm_pkg.sv @@
// Types, codes and helper functions for the i2c byte master.
// No dependencies; used by i2cbm_csr, i2cbm_core and i2c_byte_master.
package i2cbm_pkg;

   localparam int TickWidth = 8;
   localparam int ByteWidth = 8;
   localparam int BitsPerByte = 8;
   localparam int MsbBit = ByteWidth - 1;

   typedef enum logic [9:0] {
      PH_IDLE       = 10'b00_0000_0001,
      PH_COND_SETUP = 10'b00_0000_0010,
      PH_COND_HIGH  = 10'b00_0000_0100,
      PH_COND_HOLD  = 10'b00_0000_1000,
      PH_BIT_SETUP  = 10'b00_0001_0000,
      PH_BIT_HIGH   = 10'b00_0010_0000,
      PH_BYTE_GAP   = 10'b00_0100_0000,
      PH_ACK_SETUP  = 10'b00_1000_0000,
      PH_ACK_HIGH   = 10'b01_0000_0000,
      PH_ACK_GAP    = 10'b10_0000_0000
   } phase_type;

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_STOP  = 2'd1,
      MODE_WRITE = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_SETUP = 2'd0,
      CSR_HIGH  = 2'd1,
      CSR_HOLD  = 2'd2,
      CSR_GAP   = 2'd3
   } csr_index_type;

   localparam logic [TickWidth-1:0] SetupReset = 8'd1;
   localparam logic [TickWidth-1:0] HighReset  = 8'd5;
   localparam logic [TickWidth-1:0] HoldReset  = 8'd4;
   localparam logic [TickWidth-1:0] GapReset   = 8'd2;

   typedef struct packed {
      logic [TickWidth-1:0] setup_ticks;
      logic [TickWidth-1:0] high_ticks;
      logic [TickWidth-1:0] hold_ticks;
      logic [TickWidth-1:0] gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic                 sda_in;
      logic                 cmd_valid;
      logic [1:0]           mode;
      logic [ByteWidth-1:0] cmd_byte;
      logic                 send_nack;
   } req_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic drive;
   } lines_type;

   typedef struct packed {
      logic                 scl_out;
      logic                 sda_out;
      logic                 sda_enable;
      logic                 busy_res;
      logic                 done_res;
      logic                 ack_received;
      logic [ByteWidth-1:0] read_byte;
   } rsp_type;

   function automatic logic [TickWidth-1:0] at_least_one(input logic [TickWidth-1:0] v);
      return (v == '0) ? TickWidth'(1) : v;
   endfunction

   function automatic logic [TickWidth-1:0] phase_len(input phase_type p, input cfg_type cfg);
      logic [TickWidth-1:0] len;
      unique case (p) inside
         PH_COND_SETUP, PH_BIT_SETUP, PH_ACK_SETUP: len = cfg.setup_ticks;
         PH_COND_HIGH, PH_BIT_HIGH, PH_ACK_HIGH:    len = cfg.high_ticks;
         PH_COND_HOLD:                              len = cfg.hold_ticks;
         default:                                   len = cfg.gap_ticks;
      endcase
      return at_least_one(len);
   endfunction

   // Line levels set on entry to a phase.
   function automatic lines_type enter_lines(input phase_type p, input mode_type mode,
                                             input logic msb, input logic nack,
                                             input lines_type cur);
      lines_type nxt;
      nxt = cur;
      unique case (p) inside
         PH_COND_SETUP: begin
            nxt.drive = 1'b1;
            nxt.sda   = (mode == MODE_START);
         end
         PH_COND_HIGH, PH_BIT_HIGH, PH_ACK_HIGH: begin
            nxt.scl = 1'b1;
         end
         PH_COND_HOLD: begin
            nxt.sda = (mode == MODE_STOP);
         end
         PH_BIT_SETUP: begin
            nxt.scl = 1'b0;
            if (mode == MODE_WRITE) begin
               nxt.drive = 1'b1;
               nxt.sda   = msb;
            end else begin
               nxt.drive = 1'b0;
               nxt.sda   = 1'b1;
            end
         end
         PH_ACK_SETUP: begin
            nxt.scl = 1'b0;
            if (mode == MODE_WRITE) begin
               nxt.drive = 1'b0;
               nxt.sda   = 1'b1;
            end else begin
               nxt.drive = 1'b1;
               nxt.sda   = nack;
            end
         end
         PH_BYTE_GAP, PH_ACK_GAP: begin
            nxt.scl = 1'b0;
         end
         default: begin
            nxt = cur;
         end
      endcase
      return nxt;
   endfunction

endpackage

@@ sv/i2c_byte_master.sv @@
// Top level of the i2c byte master: request register, phase sequencer, result register.
// Depends on i2cbm_pkg, i2cbm_csr, i2cbm_core and i2c_byte_master_assert.svh.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  sda_in, cmd_valid, mode, cmd_byte, send_nack
//   rsp_      out         rsp_valid / rsp_stall  scl, sda, sda_enable, busy, done, ack, byte
//   csr_      in          csr_wr_en              csr_index, csr_wdata
//
// One request (one tick) per clock unless stalled; each request yields one response.
// The sequencer state advances only as a request moves from the request register to the
// result register, so the rate is limited by that single step and by rsp_stall alone.
// Reset is synchronous; no clearing pass.
// While rsp_stall holds the result register, a full request register holds and req_stall rises.
module i2c_byte_master (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_sda_in,
   input  logic                                  req_cmd_valid,
   input  logic [1:0]                            req_mode,
   input  logic [i2cbm_pkg::ByteWidth-1:0]       req_cmd_byte,
   input  logic                                  req_send_nack,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_scl_out,
   output logic                                  rsp_sda_out,
   output logic                                  rsp_sda_enable,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic                                  rsp_ack_received,
   output logic [i2cbm_pkg::ByteWidth-1:0]       rsp_read_byte,
   input  logic                                  csr_wr_en,
   input  logic [1:0]                            csr_index,
   input  logic [i2cbm_pkg::TickWidth-1:0]       csr_wdata
);
   import i2cbm_pkg::*;
   `include "i2c_byte_master_assert.svh"

   logic     req_valid_ff;
   req_type  req_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;
   cfg_type  cfg;
   rsp_type  result;
   logic     advance;
   logic     step_en;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step_en   = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= '{sda_in: req_sda_in, cmd_valid: req_cmd_valid, mode: req_mode,
                     cmd_byte: req_cmd_byte, send_nack: req_send_nack};
      end
   end

   i2cbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cbm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (req_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_out      = rsp_ff.scl_out;
   assign rsp_sda_out      = rsp_ff.sda_out;
   assign rsp_sda_enable   = rsp_ff.sda_enable;
   assign rsp_busy_res     = rsp_ff.busy_res;
   assign rsp_done_res     = rsp_ff.done_res;
   assign rsp_ack_received = rsp_ff.ack_received;
   assign rsp_read_byte    = rsp_ff.read_byte;

   `I2CBM_ASSERT_NEXT(a_step_fills_rsp, clock, reset, step_en, rsp_valid_ff, "stepped request did not reach the result register")
   `I2CBM_ASSERT_NOW(a_done_is_busy, clock, reset, rsp_valid_ff && rsp_ff.done_res, rsp_ff.busy_res, "done without busy")
   `I2CBM_ASSERT_NEXT(a_held_req_stays, clock, reset, req_valid_ff && !advance, req_valid_ff, "request register dropped while stalled")

endmodule

@@ sv/i2cbm_csr.sv @@
// Timing registers of the i2c byte master: four tick counts behind a plain write port.
// Depends on i2cbm_pkg.
module i2cbm_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [1:0]                            csr_index,
   input  logic [i2cbm_pkg::TickWidth-1:0]       csr_wdata,
   output i2cbm_pkg::cfg_type                    cfg
);
   import i2cbm_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setup_ticks <= SetupReset;
         cfg_ff.high_ticks  <= HighReset;
         cfg_ff.hold_ticks  <= HoldReset;
         cfg_ff.gap_ticks   <= GapReset;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SETUP: cfg_ff.setup_ticks <= csr_wdata;
            CSR_HIGH:  cfg_ff.high_ticks  <= csr_wdata;
            CSR_HOLD:  cfg_ff.hold_ticks  <= csr_wdata;
            CSR_GAP:   cfg_ff.gap_ticks   <= csr_wdata;
            default:   cfg_ff             <= cfg_ff;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/i2cbm_core.sv @@
// Bus phase sequencer of the i2c byte master: one tick per step, result formed combinationally.
// Depends on i2cbm_pkg and i2c_byte_master_assert.svh.
module i2cbm_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  i2cbm_pkg::req_type   item,
   input  i2cbm_pkg::cfg_type   cfg,
   output i2cbm_pkg::rsp_type   result
);
   import i2cbm_pkg::*;
   `include "i2c_byte_master_assert.svh"

   phase_type               phase_ff, phase_in;
   mode_type                mode_ff, mode_in;
   logic [3:0]              bit_count_ff, bit_count_in;
   logic [TickWidth-1:0]    tick_count_ff, tick_count_in;
   logic [ByteWidth-1:0]    shift_ff, shift_in;
   logic                    nack_ff, nack_in;
   logic                    ack_ff, ack_in;
   logic [ByteWidth-1:0]    read_hold_ff, read_hold_in;
   lines_type               lines_ff, lines_in;

   lines_type               lines_vis;
   phase_type               next_phase;
   logic                    finish;
   logic                    busy;
   logic                    done;

   always_comb begin
      phase_in      = phase_ff;
      mode_in       = mode_ff;
      bit_count_in  = bit_count_ff;
      tick_count_in = tick_count_ff;
      shift_in      = shift_ff;
      nack_in       = nack_ff;
      ack_in        = ack_ff;
      read_hold_in  = read_hold_ff;
      lines_in      = lines_ff;
      next_phase    = PH_IDLE;
      finish        = 1'b0;
      busy          = 1'b0;
      done          = 1'b0;

      // Take a new command only when idle.
      if (phase_ff == PH_IDLE && item.cmd_valid) begin
         mode_in       = mode_type'(item.mode);
         shift_in      = (mode_in == MODE_WRITE) ? item.cmd_byte : '0;
         nack_in       = item.send_nack;
         bit_count_in  = '0;
         tick_count_in = '0;
         phase_in      = (mode_in == MODE_START || mode_in == MODE_STOP) ?
                         PH_COND_SETUP : PH_BIT_SETUP;
         lines_in      = enter_lines(phase_in, mode_in, shift_in[MsbBit], nack_in, lines_in);
      end

      lines_vis = lines_in;

      if (phase_in != PH_IDLE) begin
         busy          = 1'b1;
         tick_count_in = tick_count_in + TickWidth'(1);
         if (tick_count_in >= phase_len(phase_in, cfg)) begin
            unique case (phase_in)
               PH_COND_SETUP: next_phase = PH_COND_HIGH;
               PH_COND_HIGH:  next_phase = PH_COND_HOLD;
               PH_COND_HOLD: begin
                  if (mode_in == MODE_START) begin
                     next_phase = PH_BYTE_GAP;
                  end else begin
                     finish = 1'b1;
                  end
               end
               PH_BIT_SETUP:  next_phase = PH_BIT_HIGH;
               PH_BIT_HIGH: begin
                  shift_in     = {shift_in[MsbBit-1:0],
                                  (mode_in == MODE_READ) ? item.sda_in : 1'b0};
                  bit_count_in = bit_count_in + 4'd1;
                  if (bit_count_in < 4'(BitsPerByte)) begin
                     next_phase = PH_BIT_SETUP;
                  end else begin
                     if (mode_in == MODE_READ) begin
                        read_hold_in = shift_in;
                     end
                     next_phase = PH_BYTE_GAP;
                  end
               end
               PH_BYTE_GAP: begin
                  if (mode_in == MODE_START) begin
                     finish = 1'b1;
                  end else begin
                     next_phase = PH_ACK_SETUP;
                  end
               end
               PH_ACK_SETUP:  next_phase = PH_ACK_HIGH;
               PH_ACK_HIGH: begin
                  // Slave ACK is SDA pulled low on the last high tick.
                  if (mode_in == MODE_WRITE) begin
                     ack_in = ~item.sda_in;
                  end
                  next_phase = PH_ACK_GAP;
               end
               PH_ACK_GAP: begin
                  lines_in.drive = 1'b1;
                  if (mode_in == MODE_WRITE) begin
                     lines_in.sda = 1'b1;
                  end
                  finish = 1'b1;
               end
               default: finish = 1'b1;
            endcase

            tick_count_in = '0;
            if (finish) begin
               done     = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               phase_in = next_phase;
               lines_in = enter_lines(phase_in, mode_in, shift_in[MsbBit], nack_in, lines_in);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         mode_ff       <= MODE_START;
         bit_count_ff  <= '0;
         tick_count_ff <= '0;
         shift_ff      <= '0;
         nack_ff       <= 1'b0;
         ack_ff        <= 1'b0;
         read_hold_ff  <= '0;
         lines_ff      <= '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
      end else if (step_en) begin
         phase_ff      <= phase_in;
         mode_ff       <= mode_in;
         bit_count_ff  <= bit_count_in;
         tick_count_ff <= tick_count_in;
         shift_ff      <= shift_in;
         nack_ff       <= nack_in;
         ack_ff        <= ack_in;
         read_hold_ff  <= read_hold_in;
         lines_ff      <= lines_in;
      end
   end

   assign result.scl_out      = lines_vis.scl;
   assign result.sda_out      = lines_vis.sda;
   assign result.sda_enable   = lines_vis.drive;
   assign result.busy_res     = busy;
   assign result.done_res     = done;
   assign result.ack_received = ack_in;
   assign result.read_byte    = read_hold_in;

   `I2CBM_ASSERT_NOW(a_idle_tick_clear, clock, reset, (phase_ff == PH_IDLE), (tick_count_ff == '0), "tick count not cleared in idle")
   `I2CBM_ASSERT_NOW(a_bit_count_range, clock, reset, (phase_ff != PH_IDLE), (bit_count_ff <= 4'(BitsPerByte)), "bit count past one byte")
   `I2CBM_ASSERT_NEXT(a_idle_no_cmd, clock, reset, (step_en && phase_ff == PH_IDLE && !item.cmd_valid), (phase_ff == PH_IDLE), "left idle without a command")

endmodule

@@ tb/i2c_byte_master_tb.sv @@
// Self-checking testbench for i2c_byte_master: random tick requests with bus commands,
// random request gaps and response stalls, every response checked against a local bus predictor.
// Depends on i2cbm_pkg and the i2c_byte_master RTL.
module i2c_byte_master_tb;
   import i2cbm_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_sda_in = 1'b1;
   logic                 req_cmd_valid = 1'b0;
   logic [1:0]           req_mode = MODE_START;
   logic [ByteWidth-1:0] req_cmd_byte = '0;
   logic                 req_send_nack = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_scl_out;
   logic                 rsp_sda_out;
   logic                 rsp_sda_enable;
   logic                 rsp_busy_res;
   logic                 rsp_done_res;
   logic                 rsp_ack_received;
   logic [ByteWidth-1:0] rsp_read_byte;
   logic                 csr_wr_en = 1'b0;
   logic [1:0]           csr_index = CSR_SETUP;
   logic [TickWidth-1:0] csr_wdata = '0;

   i2c_byte_master i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sda_in       (req_sda_in),
      .req_cmd_valid    (req_cmd_valid),
      .req_mode         (req_mode),
      .req_cmd_byte     (req_cmd_byte),
      .req_send_nack    (req_send_nack),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_out      (rsp_scl_out),
      .rsp_sda_out      (rsp_sda_out),
      .rsp_sda_enable   (rsp_sda_enable),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_ack_received (rsp_ack_received),
      .rsp_read_byte    (rsp_read_byte),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Timing registers as last written; shared by the predictor and the stimulus.
   cfg_type  timing;

   req_type  tick_reqs_q[$];
   rsp_type  tick_results_q[$];
   int       ticks_queued = 0;
   int       ticks_sent = 0;
   int       mismatch_count = 0;
   logic     req_taken = 1'b0;

   // Bus predictor state
   phase_type            bus_ph;
   mode_type             bus_mode;
   logic [3:0]           bit_cnt;
   logic [TickWidth-1:0] tick_cnt;
   logic [ByteWidth-1:0] shift_q;
   logic [ByteWidth-1:0] rd_hold;
   logic                 nack_q, ack_q, scl_q, sda_q, drv_q;

   function automatic int eff_ticks(logic [TickWidth-1:0] v);
      return (v == '0) ? 1 : int'(v);
   endfunction

   function automatic int ticks_of(phase_type p);
      case (p) inside
         PH_COND_SETUP, PH_BIT_SETUP, PH_ACK_SETUP: return eff_ticks(timing.setup_ticks);
         PH_COND_HIGH, PH_BIT_HIGH, PH_ACK_HIGH:    return eff_ticks(timing.high_ticks);
         PH_COND_HOLD:                              return eff_ticks(timing.hold_ticks);
         default:                                   return eff_ticks(timing.gap_ticks);
      endcase
   endfunction

   function automatic void enter_phase(phase_type p);
      bus_ph = p;
      tick_cnt = '0;
      case (p) inside
         PH_COND_SETUP: begin
            drv_q = 1'b1;
            sda_q = (bus_mode == MODE_START);
         end
         PH_COND_HIGH, PH_BIT_HIGH, PH_ACK_HIGH: scl_q = 1'b1;
         PH_COND_HOLD: sda_q = (bus_mode == MODE_STOP);
         PH_BIT_SETUP: begin
            scl_q = 1'b0;
            drv_q = (bus_mode == MODE_WRITE);
            sda_q = (bus_mode == MODE_WRITE) ? shift_q[MsbBit] : 1'b1;
         end
         PH_ACK_SETUP: begin
            scl_q = 1'b0;
            drv_q = (bus_mode != MODE_WRITE);
            sda_q = (bus_mode == MODE_WRITE) ? 1'b1 : nack_q;
         end
         PH_BYTE_GAP, PH_ACK_GAP: scl_q = 1'b0;
         default: ;
      endcase
   endfunction

   // Act on the last tick of a phase; return 1 when the command is over.
   function automatic logic close_phase(logic sda);
      logic fin;
      fin = 1'b0;
      case (bus_ph)
         PH_COND_SETUP: enter_phase(PH_COND_HIGH);
         PH_COND_HIGH:  enter_phase(PH_COND_HOLD);
         PH_COND_HOLD: begin
            if (bus_mode == MODE_START) enter_phase(PH_BYTE_GAP);
            else fin = 1'b1;
         end
         PH_BIT_SETUP:  enter_phase(PH_BIT_HIGH);
         PH_BIT_HIGH: begin
            shift_q = {shift_q[MsbBit-1:0], (bus_mode == MODE_READ) ? sda : 1'b0};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < BitsPerByte) begin
               enter_phase(PH_BIT_SETUP);
            end else begin
               if (bus_mode == MODE_READ) rd_hold = shift_q;
               enter_phase(PH_BYTE_GAP);
            end
         end
         PH_BYTE_GAP: begin
            if (bus_mode == MODE_START) fin = 1'b1;
            else enter_phase(PH_ACK_SETUP);
         end
         PH_ACK_SETUP:  enter_phase(PH_ACK_HIGH);
         PH_ACK_HIGH: begin
            if (bus_mode == MODE_WRITE) ack_q = ~sda;
            enter_phase(PH_ACK_GAP);
         end
         default: begin
            drv_q = 1'b1;
            if (bus_mode == MODE_WRITE) sda_q = 1'b1;
            fin = 1'b1;
         end
      endcase
      return fin;
   endfunction

   function automatic rsp_type bus_tick(req_type t);
      rsp_type r;
      if (bus_ph == PH_IDLE && t.cmd_valid) begin
         bus_mode = mode_type'(t.mode);
         shift_q  = (bus_mode == MODE_WRITE) ? t.cmd_byte : '0;
         nack_q   = t.send_nack;
         bit_cnt  = '0;
         enter_phase((bus_mode == MODE_START || bus_mode == MODE_STOP) ?
                     PH_COND_SETUP : PH_BIT_SETUP);
      end
      r.scl_out    = scl_q;
      r.sda_out    = sda_q;
      r.sda_enable = drv_q;
      r.busy_res   = 1'b0;
      r.done_res   = 1'b0;
      if (bus_ph != PH_IDLE) begin
         r.busy_res = 1'b1;
         tick_cnt = tick_cnt + 1'b1;
         if (int'(tick_cnt) >= ticks_of(bus_ph)) begin
            if (close_phase(t.sda_in)) begin
               r.done_res = 1'b1;
               bus_ph = PH_IDLE;
               tick_cnt = '0;
            end
         end
      end
      r.ack_received = ack_q;
      r.read_byte    = rd_hold;
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Request driver: bursts of requests with random gaps; hold a stalled request.
   int     burst_left = 0;
   int     gap_left = 0;
   req_type drv_item;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (tick_reqs_q.size() > 0) begin
         drv_item = tick_reqs_q.pop_front();
         req_valid     <= 1'b1;
         req_sda_in    <= drv_item.sda_in;
         req_cmd_valid <= drv_item.cmd_valid;
         req_mode      <= drv_item.mode;
         req_cmd_byte  <= drv_item.cmd_byte;
         req_send_nack <= drv_item.send_nack;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 60);
            gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Response side: stall on changing patterns, plus one long hold-off while requests pile up.
   int   hold_left = 0;
   logic hold_done = 1'b0;
   int   stall_mode = 0;
   int   stall_cnt = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && ticks_sent > 450 && tick_reqs_q.size() > 40) begin
         rsp_stall <= 1'b1;
         hold_left <= 200;
         hold_done <= 1'b1;
      end else begin
         if (stall_cnt == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_cnt  <= $urandom_range(16, 80);
         end else begin
            stall_cnt <= stall_cnt - 1;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= stall_cnt[2];
         endcase
      end
   end

   // Predict on each accepted request, check each accepted response.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
         bus_ph   = PH_IDLE;
         bus_mode = MODE_START;
         bit_cnt  = '0;
         tick_cnt = '0;
         shift_q  = '0;
         rd_hold  = '0;
         nack_q   = 1'b0;
         ack_q    = 1'b0;
         scl_q    = 1'b1;
         sda_q    = 1'b1;
         drv_q    = 1'b1;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            tick_results_q.push_back(bus_tick('{sda_in: req_sda_in, cmd_valid: req_cmd_valid,
                                                mode: req_mode, cmd_byte: req_cmd_byte,
                                                send_nack: req_send_nack}));
            ticks_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (tick_results_q.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               want = tick_results_q.pop_front();
               check_field("scl_out", 8'(want.scl_out), 8'(rsp_scl_out));
               check_field("sda_out", 8'(want.sda_out), 8'(rsp_sda_out));
               check_field("sda_enable", 8'(want.sda_enable), 8'(rsp_sda_enable));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_busy_res));
               check_field("done_res", 8'(want.done_res), 8'(rsp_done_res));
               check_field("ack_received", 8'(want.ack_received), 8'(rsp_ack_received));
               check_field("read_byte", want.read_byte, rsp_read_byte);
            end
         end
      end
   end

   // Stimulus

   function automatic int cmd_ticks(mode_type m);
      int s, h, o, g;
      s = eff_ticks(timing.setup_ticks);
      h = eff_ticks(timing.high_ticks);
      o = eff_ticks(timing.hold_ticks);
      g = eff_ticks(timing.gap_ticks);
      case (m)
         MODE_START: return s + h + o + g;
         MODE_STOP:  return s + h + o;
         default:    return BitsPerByte * (s + h) + s + h + 2 * g;
      endcase
   endfunction

   function automatic void queue_idle(int n);
      req_type t;
      repeat (n) begin
         t = '{sda_in: 1'($urandom_range(0, 1)), cmd_valid: 1'b0,
               mode: 2'($urandom_range(0, 3)), cmd_byte: 8'($urandom_range(0, 255)),
               send_nack: 1'($urandom_range(0, 1))};
         tick_reqs_q.push_back(t);
         ticks_queued++;
      end
   endfunction

   // Issue a command on an idle tick and cover its whole run; sda_fill 2 means random SDA.
   // Noisy commands also carry ignored commands while busy.
   function automatic void queue_cmd(mode_type m, logic [7:0] b, logic nk, int sda_fill,
                                     bit noisy);
      req_type t;
      int      n;
      n = cmd_ticks(m);
      for (int i = 0; i < n; i++) begin
         t.sda_in = (sda_fill > 1) ? 1'($urandom_range(0, 1)) : 1'(sda_fill);
         if (i == 0) begin
            t.cmd_valid = 1'b1;
            t.mode      = m;
            t.cmd_byte  = b;
            t.send_nack = nk;
         end else begin
            t.cmd_valid = noisy && ($urandom_range(0, 5) == 0);
            t.mode      = 2'($urandom_range(0, 3));
            t.cmd_byte  = 8'($urandom_range(0, 255));
            t.send_nack = 1'($urandom_range(0, 1));
         end
         tick_reqs_q.push_back(t);
         ticks_queued++;
      end
   endfunction

   function automatic void queue_any(mode_type m);
      queue_cmd(m, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 2,
                $urandom_range(0, 3) == 0);
   endfunction

   // Mostly well-formed transactions: start, one to three bytes, stop.
   task automatic queue_traffic(int n);
      int goal;
      goal = ticks_queued + n;
      while (ticks_queued < goal) begin
         if ($urandom_range(0, 9) < 7) begin
            queue_any(MODE_START);
            repeat ($urandom_range(1, 3)) queue_any($urandom_range(0, 1) ? MODE_WRITE : MODE_READ);
            queue_any(MODE_STOP);
         end else begin
            queue_any(mode_type'($urandom_range(0, 3)));
         end
         queue_idle($urandom_range(0, 2));
      end
   endtask

   // Drain all requests and responses and let the bus command run out.
   task automatic settle();
      forever begin
         while (tick_reqs_q.size() != 0 || req_valid || tick_results_q.size() != 0)
            @(negedge clock);
         if (bus_ph == PH_IDLE) break;
         queue_idle(8);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic set_timing(logic [7:0] s, logic [7:0] h, logic [7:0] o, logic [7:0] g);
      timing.setup_ticks = s;
      timing.high_ticks  = h;
      timing.hold_ticks  = o;
      timing.gap_ticks   = g;
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SETUP;
      csr_wdata <= s;
      @(negedge clock);
      csr_index <= CSR_HIGH;
      csr_wdata <= h;
      @(negedge clock);
      csr_index <= CSR_HOLD;
      csr_wdata <= o;
      @(negedge clock);
      csr_index <= CSR_GAP;
      csr_wdata <= g;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      timing = '{setup_ticks: SetupReset, high_ticks: HighReset,
                 hold_ticks: HoldReset, gap_ticks: GapReset};
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed at reset timing: lines before any command, stop from idle, ACK and
      // NACK on writes, reads of all ones and all zeros, repeated start, busy commands.
      queue_idle(2);
      queue_cmd(MODE_STOP, 8'h00, 1'b0, 2, 1'b0);
      queue_cmd(MODE_START, 8'hFF, 1'b1, 2, 1'b0);
      queue_cmd(MODE_WRITE, 8'h00, 1'b0, 0, 1'b0);
      queue_cmd(MODE_WRITE, 8'hFF, 1'b1, 1, 1'b0);
      queue_cmd(MODE_READ, 8'h5A, 1'b0, 1, 1'b0);
      queue_idle(3);
      queue_cmd(MODE_READ, 8'hA5, 1'b1, 0, 1'b0);
      queue_cmd(MODE_START, 8'h00, 1'b0, 2, 1'b1);
      queue_cmd(MODE_WRITE, 8'hA5, 1'b0, 2, 1'b1);
      queue_cmd(MODE_STOP, 8'hFF, 1'b1, 2, 1'b1);
      queue_cmd(MODE_STOP, 8'h00, 1'b0, 2, 1'b0);
      queue_idle(2);
      settle();

      set_timing(8'd1, 8'd1, 8'd1, 8'd1);
      queue_traffic(350);
      settle();

      // Zero register values count as one tick.
      set_timing(8'd0, 8'd0, 8'd0, 8'd0);
      queue_traffic(80);
      settle();

      repeat (2) begin
         set_timing(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                    8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
         queue_traffic(60);
         settle();
      end

      // Longest phase: a full-range hold count.
      set_timing(8'd1, 8'd1, 8'd255, 8'd1);
      queue_any(MODE_STOP);
      settle();

      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && tick_results_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
